// ===== design/ring_bus_frame_receiver_core_macros.svh =====
// Assertion macros for the ring bus frame receiver checker
`ifndef RING_BUS_FRAME_RECEIVER_CORE_MACROS_SVH
`define RING_BUS_FRAME_RECEIVER_CORE_MACROS_SVH

// Clocked check, quiet while reset is asserted
`define RBFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define RBFR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rbfr_pkg.sv =====
// Types, codes and the CRC-16 byte update for the ring bus frame receiver
package rbfr_pkg;

	// Defaults for the top level parameters
	localparam int MAX_LEN_DEF  = 34;
	localparam int NUM_ADDR_DEF = 16;

	// Preamble, address, CRC and timeout constants
	localparam logic [7:0]  PRE0         = 8'hA5;
	localparam logic [7:0]  PRE1         = 8'h5A;
	localparam logic [4:0]  UNASSIGNED   = 5'd16;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [7:0]  TIMEOUT_RST  = 8'd25;
	localparam logic [15:0] CRC_SEED_RST = 16'hFFFF;

	// Operation codes of an input transaction
	localparam logic [1:0] OP_BYTE     = 2'd0;
	localparam logic [1:0] OP_TICK     = 2'd1;
	localparam logic [1:0] OP_OVERFLOW = 2'd2;

	// Configuration register indexes
	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_SEED    = 1'b1;

	// Command bytes
	localparam logic [7:0] CMD_STORE_FWD = 8'h01;
	localparam logic [7:0] CMD_CUT_THRU  = 8'h02;
	localparam logic [7:0] CMD_SET_ADDR  = 8'h03;
	localparam logic [7:0] CMD_DUTY      = 8'h10;

	// Frame kinds
	localparam logic [2:0] KIND_STORE_FWD = 3'd0;
	localparam logic [2:0] KIND_CUT_THRU  = 3'd1;
	localparam logic [2:0] KIND_SET_ADDR  = 3'd2;
	localparam logic [2:0] KIND_DUTY      = 3'd3;
	localparam logic [2:0] KIND_TO_ME     = 3'd4;
	localparam logic [2:0] KIND_TO_OTHER  = 3'd5;
	localparam logic [2:0] KIND_STATUS    = 3'd6;
	localparam logic [2:0] KIND_IGNORED   = 3'd7;

	// Reply modes
	localparam logic [1:0] REPLY_FULL = 2'd0;
	localparam logic [1:0] REPLY_ACK  = 2'd1;
	localparam logic [1:0] REPLY_NONE = 2'd2;

	// Sub-command limits
	localparam logic [5:0] SUB_QUERY_A = 6'h10;
	localparam logic [5:0] SUB_QUERY_B = 6'h11;
	localparam logic [5:0] SUB_MAX     = 6'h13;

	typedef enum logic [1:0] {
		PH_SCAN0,
		PH_SCAN1,
		PH_BUF
	} phase_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic               crc_ok;
		logic [2:0]         frame_kind;
		logic [7:0]         command;
		logic [5:0]         payload_len;
		logic               forward;
		logic [5:0]         sub_command;
		logic [1:0]         reply_sel;
		logic signed [15:0] slot_duty;
		logic               slot_duty_valid;
		logic [4:0]         next_address;
		logic               address_reply;
		logic [4:0]         own_address;
	} result_t;

	// Captured frame context handed to the classifier
	typedef struct packed {
		logic        crc_match;
		logic [7:0]  command;
		logic [7:0]  second;
		logic [15:0] duty;
		logic [4:0]  device_address;
		logic        forward_mode;
		logic        start_mode;
	} frame_info_t;

	// State updates decided by the classifier
	typedef struct packed {
		logic [4:0] device_address;
		logic       forward_mode;
	} frame_upd_t;

	// CRC-16-CCITT, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== design/rbfr_classify.sv =====
// Frame classifier: command class, forwarding, enumeration, duty slot, sub-commands
module rbfr_classify #(
	parameter int MAX_LEN       = rbfr_pkg::MAX_LEN_DEF,
	parameter int NUM_ADDRESSES = rbfr_pkg::NUM_ADDR_DEF,
	localparam int POS_W        = $clog2(MAX_LEN + 4)
) (
	input  rbfr_pkg::frame_info_t info,
	input  logic [POS_W-1:0]      frame_len,
	output rbfr_pkg::result_t     result,
	output rbfr_pkg::frame_upd_t  upd
);

	logic       assigned;
	logic       len_ge2;
	logic [7:0] raw;
	logic [5:0] sub;
	logic [1:0] rm;
	logic [5:0] slot_end;

	assign assigned = (info.device_address != rbfr_pkg::UNASSIGNED);
	assign len_ge2  = (frame_len >= POS_W'(2));
	assign raw      = len_ge2 ? info.second : 8'h00;
	assign sub      = raw[5:0];
	// 2 + 2 * address, the slot must end inside the payload
	assign slot_end = {1'b0, info.device_address[3:0], 1'b0} + 6'd2;

	// Reply mode for an addressed command
	always_comb begin
		case (raw[7:6])
			2'b01:   rm = rbfr_pkg::REPLY_ACK;
			2'b10:   rm = rbfr_pkg::REPLY_NONE;
			default: rm = rbfr_pkg::REPLY_FULL;
		endcase
		if (sub == rbfr_pkg::SUB_QUERY_A || sub == rbfr_pkg::SUB_QUERY_B)
			rm = rbfr_pkg::REPLY_FULL;
		if (sub == 6'd0 || sub > rbfr_pkg::SUB_MAX)
			rm = rbfr_pkg::REPLY_NONE;
	end

	// Classification and state updates
	always_comb begin
		result = '0;
		upd.device_address = info.device_address;
		upd.forward_mode   = info.forward_mode;
		if (info.crc_match) begin
			result.frame_kind = rbfr_pkg::KIND_IGNORED;
			case (info.command)
				rbfr_pkg::CMD_STORE_FWD: begin
					result.frame_kind = rbfr_pkg::KIND_STORE_FWD;
					upd.forward_mode  = 1'b1;
					result.forward    = info.start_mode;
				end
				rbfr_pkg::CMD_CUT_THRU: begin
					result.frame_kind = rbfr_pkg::KIND_CUT_THRU;
					upd.forward_mode  = 1'b0;
					result.forward    = info.start_mode;
				end
				rbfr_pkg::CMD_SET_ADDR: begin
					result.frame_kind = rbfr_pkg::KIND_SET_ADDR;
					if (len_ge2 && info.second < 8'(NUM_ADDRESSES)) begin
						if (!assigned)
							upd.device_address = info.second[4:0];
						result.next_address  = info.second[4:0] + 5'd1;
						result.address_reply = 1'b1;
					end
				end
				rbfr_pkg::CMD_DUTY: begin
					result.frame_kind = rbfr_pkg::KIND_DUTY;
					if (assigned && {3'b000, slot_end} < 9'(frame_len)) begin
						result.slot_duty       = info.duty;
						result.slot_duty_valid = 1'b1;
						result.forward         = info.forward_mode;
					end
				end
				default: begin
					if (info.command inside {[8'h20:8'h2F]}) begin
						if (!assigned || {1'b0, info.command[3:0]} != info.device_address) begin
							result.frame_kind = rbfr_pkg::KIND_TO_OTHER;
							result.forward    = info.forward_mode;
						end else begin
							result.frame_kind  = rbfr_pkg::KIND_TO_ME;
							result.sub_command = sub;
							result.reply_sel   = rm;
						end
					end else if (info.command inside {[8'h40:8'h5F]}) begin
						result.frame_kind = rbfr_pkg::KIND_STATUS;
						result.forward    = info.forward_mode;
					end
				end
			endcase
			result.crc_ok      = 1'b1;
			result.command     = info.command;
			result.payload_len = 6'(frame_len);
			result.own_address = upd.device_address;
		end
	end

endmodule

// ===== design/ring_bus_frame_receiver_core.sv =====
// Ring bus frame receiver: preamble hunt, length, payload, CRC check, frame decode
//
//   channel   | signals                              | accepted when
//   ----------+--------------------------------------+------------------------------
//   item      | item_valid, item_ready, item         | item_valid && item_ready
//   result    | result_valid, result_ready, result   | result_valid && result_ready
//   config    | cfg_wr_en, cfg_index, cfg_data       | cfg_wr_en
//
// One transaction per cycle sustained while the result channel is not stalled; a frame result
// is offered once its last CRC byte has passed the input register, then the result register.
// The CRC byte update and the frame classifier sit between those two registers.
// Reset clears all control state and returns to hunting for the preamble.
// A stalled result holds the result register; one more item waits in the input register.
module ring_bus_frame_receiver_core #(
	parameter int MAX_LEN       = rbfr_pkg::MAX_LEN_DEF,
	parameter int NUM_ADDRESSES = rbfr_pkg::NUM_ADDR_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rbfr_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output rbfr_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int POS_W = $clog2(MAX_LEN + 4);

	// Input register
	logic            item_valid_s1;
	rbfr_pkg::item_t item_s1;
	logic            advance;

	// Configuration
	logic [7:0]  timeout_ticks_q;
	logic [15:0] crc_seed_q;

	// Receiver state
	rbfr_pkg::phase_t phase_q, phase_n;
	logic [POS_W-1:0] byte_pos_q;
	logic [7:0]       timeout_q;
	logic [15:0]      crc_q;
	logic [7:0]       rcv_hi_q;
	logic [POS_W-1:0] frame_len_q;
	logic [7:0]       cmd_q;
	logic [7:0]       second_q;
	logic [15:0]      duty_q;
	logic [4:0]       dev_addr_q;
	logic             relay_mode_q;
	logic             start_mode_q;

	// Result register
	logic              result_valid_q;
	rbfr_pkg::result_t result_q;

	// Decode of the current transaction
	logic [1:0]       op;
	logic [7:0]       b;
	logic             buf_byte;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] idx;
	logic [8:0]       idx_x;
	logic [8:0]       off_x;
	logic             is_len;
	logic             bad_len;
	logic             is_pay;
	logic             is_crc_hi;
	logic             finish;
	logic [15:0]      crc_upd;

	rbfr_pkg::frame_info_t info;
	rbfr_pkg::result_t     cls_result;
	rbfr_pkg::frame_upd_t  cls_upd;

	assign advance    = item_valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !item_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= rbfr_pkg::TIMEOUT_RST;
			crc_seed_q      <= rbfr_pkg::CRC_SEED_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rbfr_pkg::CFG_TIMEOUT: timeout_ticks_q <= cfg_data[7:0];
				rbfr_pkg::CFG_SEED:    crc_seed_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte position decode inside a frame
	assign op        = item_s1.operation;
	assign b         = item_s1.data_byte;
	assign buf_byte  = (op == rbfr_pkg::OP_BYTE) && (phase_q == rbfr_pkg::PH_BUF);
	assign pos_n     = byte_pos_q + POS_W'(1);
	assign idx       = pos_n - POS_W'(2);
	assign idx_x     = 9'(idx);
	assign off_x     = {4'b0000, dev_addr_q[3:0], 1'b1};
	assign is_len    = (pos_n == POS_W'(1));
	assign bad_len   = (b == 8'd0) || (b > 8'(MAX_LEN));
	assign is_pay    = !is_len && (pos_n <= frame_len_q + POS_W'(1));
	assign is_crc_hi = !is_len && !is_pay && (pos_n == frame_len_q + POS_W'(2));
	assign finish    = buf_byte && !is_len && !is_pay && !is_crc_hi;
	assign crc_upd   = rbfr_pkg::crc16_byte(crc_q, b);

	// Frame classifier
	assign info.crc_match      = (crc_q == {rcv_hi_q, b});
	assign info.command        = cmd_q;
	assign info.second         = second_q;
	assign info.duty           = duty_q;
	assign info.device_address = dev_addr_q;
	assign info.forward_mode   = relay_mode_q;
	assign info.start_mode     = start_mode_q;

	rbfr_classify #(
		.MAX_LEN       (MAX_LEN),
		.NUM_ADDRESSES (NUM_ADDRESSES)
	) u_classify (
		.info      (info),
		.frame_len (frame_len_q),
		.result    (cls_result),
		.upd       (cls_upd)
	);

	// Receive phase next state
	always_comb begin
		phase_n = phase_q;
		if (advance) begin
			case (op)
				rbfr_pkg::OP_OVERFLOW: phase_n = rbfr_pkg::PH_SCAN0;
				rbfr_pkg::OP_TICK: begin
					if (phase_q != rbfr_pkg::PH_SCAN0 && timeout_q == 8'd1)
						phase_n = rbfr_pkg::PH_SCAN0;
				end
				rbfr_pkg::OP_BYTE: begin
					case (phase_q)
						rbfr_pkg::PH_SCAN0: begin
							if (b == rbfr_pkg::PRE0)
								phase_n = rbfr_pkg::PH_SCAN1;
						end
						rbfr_pkg::PH_SCAN1: begin
							if (b == rbfr_pkg::PRE1)
								phase_n = rbfr_pkg::PH_BUF;
							else if (b != rbfr_pkg::PRE0)
								phase_n = rbfr_pkg::PH_SCAN0;
						end
						rbfr_pkg::PH_BUF: begin
							if ((is_len && bad_len) || finish)
								phase_n = rbfr_pkg::PH_SCAN0;
						end
						default: phase_n = rbfr_pkg::PH_SCAN0;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= rbfr_pkg::PH_SCAN0;
		else
			phase_q <= phase_n;
	end

	// Frame datapath: position, timeout, CRC and captured bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= '0;
			timeout_q    <= 8'd0;
			crc_q        <= rbfr_pkg::CRC_SEED_RST;
			rcv_hi_q     <= 8'd0;
			frame_len_q  <= '0;
			cmd_q        <= 8'd0;
			second_q     <= 8'd0;
			duty_q       <= 16'd0;
			dev_addr_q   <= rbfr_pkg::UNASSIGNED;
			relay_mode_q <= 1'b0;
			start_mode_q <= 1'b0;
		end else if (advance) begin
			case (op)
				rbfr_pkg::OP_OVERFLOW: begin
					byte_pos_q <= '0;
					timeout_q  <= 8'd0;
				end
				rbfr_pkg::OP_TICK: begin
					if (phase_q != rbfr_pkg::PH_SCAN0 && timeout_q != 8'd0) begin
						timeout_q <= timeout_q - 8'd1;
						if (timeout_q == 8'd1)
							byte_pos_q <= '0;
					end
				end
				rbfr_pkg::OP_BYTE: begin
					case (phase_q)
						rbfr_pkg::PH_SCAN0: begin
							if (b == rbfr_pkg::PRE0)
								timeout_q <= timeout_ticks_q;
						end
						rbfr_pkg::PH_SCAN1: begin
							if (b == rbfr_pkg::PRE1) begin
								byte_pos_q   <= '0;
								start_mode_q <= relay_mode_q;
								timeout_q    <= timeout_ticks_q;
								crc_q        <= crc_seed_q;
								rcv_hi_q     <= 8'd0;
								cmd_q        <= 8'd0;
								second_q     <= 8'd0;
								duty_q       <= 16'd0;
							end else if (b == rbfr_pkg::PRE0) begin
								timeout_q <= timeout_ticks_q;
							end else begin
								timeout_q <= 8'd0;
							end
						end
						rbfr_pkg::PH_BUF: begin
							// A bad length or the last CRC byte ends the frame
							if ((is_len && bad_len) || finish) begin
								byte_pos_q <= '0;
								timeout_q  <= 8'd0;
							end else begin
								byte_pos_q <= pos_n;
								timeout_q  <= timeout_ticks_q;
							end
							if (is_len) begin
								if (!bad_len) begin
									frame_len_q <= POS_W'(b);
									crc_q       <= crc_upd;
								end
							end else if (is_pay) begin
								crc_q <= crc_upd;
								if (idx == '0)
									cmd_q <= b;
								if (idx == POS_W'(1))
									second_q <= b;
								if (dev_addr_q != rbfr_pkg::UNASSIGNED) begin
									if (idx_x == off_x)
										duty_q[15:8] <= b;
									else if (idx_x == off_x + 9'd1)
										duty_q[7:0] <= b;
								end
							end else if (is_crc_hi) begin
								rcv_hi_q <= b;
							end else begin
								// Last CRC byte: apply decoded updates
								dev_addr_q   <= cls_upd.device_address;
								relay_mode_q <= cls_upd.forward_mode;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= finish;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && finish)
			result_q <= cls_result;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== design/rbfr_checker.sv =====
// Port-level checker for the ring bus frame receiver, bound to the top level
`include "ring_bus_frame_receiver_core_macros.svh"

module rbfr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input rbfr_pkg::result_t result
);

	// A shown result stays until taken
	`RBFR_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid, "result dropped while stalled")

	// A failed CRC leaves every other field at zero
	`RBFR_ASSERT(a_crc_fail_zero, result_valid && !result.crc_ok |-> result.frame_kind == 3'd0 && result.command == 8'd0 && result.payload_len == 6'd0 && result.own_address == 5'd0 && !result.forward, "nonzero fields on CRC failure")

	// Duty slot only on a broadcast duty frame
	`RBFR_ASSERT(a_duty_kind, result_valid && result.slot_duty_valid |-> result.crc_ok && result.frame_kind == rbfr_pkg::KIND_DUTY, "duty slot outside duty frame")

	// Enumeration reply only on a set-address frame, with a nonzero next address
	`RBFR_ASSERT(a_addr_reply, result_valid && result.address_reply |-> result.frame_kind == rbfr_pkg::KIND_SET_ADDR && result.next_address != 5'd0, "bad set-address reply")

	// A reset edge leaves no result offered
	`RBFR_ASSERT_RST(a_reset_quiet, !arst_n |=> !result_valid, "result valid after reset")

endmodule

bind ring_bus_frame_receiver_core rbfr_checker u_rbfr_checker (.*);
